@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is low.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  `ASSERT_ALWAYS(lbl, clk, rst_n, (ante) |-> (cons))

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `ASSERT_ALWAYS(lbl, clk, rst_n, (ante) |=> (cons))

`endif

@@ design/mfre_pkg.sv @@
package mfre_pkg;

  localparam int DIM_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int OP_W      = 2;
  localparam int XF_W      = 3;
  localparam int VALUE_W   = 32;
  localparam int COORD_W   = 7;

  typedef logic [DIM_W-1:0] dim_t;

  localparam dim_t DIM_RESET = 8'd2;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_XFORM = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [XF_W-1:0] {
    XF_VFLIP    = 3'd0,
    XF_HFLIP    = 3'd1,
    XF_ROT_CW   = 3'd2,
    XF_ROT_CCW  = 3'd3,
    XF_QUAD_CW  = 3'd4,
    XF_QUAD_CCW = 3'd5
  } xform_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 1'b0,
    CFG_COLS = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE  = 2'd0,
    SEQ_FLIP  = 2'd1,
    SEQ_COPY  = 2'd2,
    SEQ_DRAIN = 2'd3
  } seq_state_e;

  typedef struct packed {
    logic busy;
    logic done;
    logic flip_bank;
    logic swap_dims;
    logic rd_en;
    logic wr_en;
    logic wr_other;
  } seq_ctrl_t;

endpackage

@@ design/mfre_in_if.sv @@
interface mfre_in_if import mfre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [OP_W-1:0]           operation;
  logic signed [VALUE_W-1:0] value;
  logic [XF_W-1:0]           transform_code;

  modport source (output valid, output operation, output value, output transform_code,
                  input ready);
  modport sink   (input valid, input operation, input value, input transform_code,
                  output ready);
endinterface

@@ design/mfre_out_if.sv @@
interface mfre_out_if import mfre_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value_res;
  logic [COORD_W-1:0]        row;
  logic [COORD_W-1:0]        col;
  logic                      last;

  modport source (output valid, output value_res, output row, output col, output last,
                  input ready);
  modport sink   (input valid, input value_res, input row, input col, input last,
                  output ready);
endinterface

@@ design/mfre_bank.sv @@
module mfre_bank #(
  parameter int DATA_WIDTH = 32,
  parameter int DEPTH      = 16384,
  parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [ADDR_WIDTH-1:0] waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [ADDR_WIDTH-1:0] raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/mfre_seq.sv @@
module mfre_seq import mfre_pkg::*; #(
  parameter int ADDR_WIDTH = 14,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  xform_e                code_i,
  input  dim_t                  rows_i,
  input  dim_t                  cols_i,
  input  logic [DATA_WIDTH-1:0] rdata_i,
  output seq_ctrl_t             ctrl_o,
  output logic [ADDR_WIDTH-1:0] rd_addr_o,
  output logic [ADDR_WIDTH-1:0] wr_addr_o,
  output logic [DATA_WIDTH-1:0] wr_data_o
);

  localparam int SW = ((ADDR_WIDTH > 2 * DIM_W) ? ADDR_WIDTH : 2 * DIM_W) + 1;

  seq_state_e state_q, state_d;
  xform_e     code_q;
  dim_t       n_q, m_q, i_q, j_q, imax_q, jmax_q;
  logic [ADDR_WIDTH-1:0] rb_q, pa_q, pb_q, wa_q;
  logic                  ph_q, pend_q, wv_q;
  logic [DATA_WIDTH-1:0] hold_q;

  dim_t                  hn, hm, ma, mb;
  logic [2*DIM_W-1:0]    prod;
  logic [SW-1:0]         s_w, p_w, d_w;
  logic [ADDR_WIDTH-1:0] a_addr, b_addr, d_addr;
  logic                  row_end, item_last, step, in_top, in_left, is_flip, is_rot;

  assign hn = {1'b0, n_q[DIM_W-1:1]};
  assign hm = {1'b0, m_q[DIM_W-1:1]};
  assign is_flip = (code_q == XF_VFLIP) || (code_q == XF_HFLIP);
  assign is_rot  = (code_q == XF_ROT_CW) || (code_q == XF_ROT_CCW);
  assign row_end   = (j_q == jmax_q);
  assign item_last = row_end && (i_q == imax_q);
  assign in_top  = (i_q < hn);
  assign in_left = (j_q < hm);

  always_comb begin
    unique case (code_q)
      XF_VFLIP:   begin ma = dim_t'(n_q - dim_t'(1) - i_q); mb = m_q; end
      XF_ROT_CW:  begin ma = j_q;                          mb = n_q; end
      XF_ROT_CCW: begin ma = dim_t'(m_q - dim_t'(1) - j_q); mb = n_q; end
      default:    begin ma = hn;                           mb = m_q; end
    endcase
  end

  assign prod = ma * mb;
  assign p_w  = SW'(prod);
  assign s_w  = SW'(rb_q) + SW'(j_q);
  assign a_addr = ADDR_WIDTH'(s_w);

  always_comb begin
    if (code_q == XF_VFLIP) begin
      b_addr = ADDR_WIDTH'(p_w + SW'(j_q));
    end else begin
      b_addr = ADDR_WIDTH'(SW'(rb_q) + SW'(dim_t'(m_q - dim_t'(1) - j_q)));
    end
  end

  always_comb begin
    unique case (code_q)
      XF_ROT_CW:  d_w = p_w + SW'(dim_t'(n_q - dim_t'(1) - i_q));
      XF_ROT_CCW: d_w = p_w + SW'(i_q);
      XF_QUAD_CW: begin
        priority if (in_top && in_left) d_w = s_w + SW'(hm);
        else if (in_top)                d_w = s_w + p_w;
        else if (!in_left)              d_w = s_w - SW'(hm);
        else                            d_w = s_w - p_w;
      end
      XF_QUAD_CCW: begin
        priority if (in_top && in_left) d_w = s_w + p_w;
        else if (in_top)                d_w = s_w - SW'(hm);
        else if (!in_left)              d_w = s_w - p_w;
        else                            d_w = s_w + SW'(hm);
      end
      default: d_w = s_w;
    endcase
  end

  assign d_addr = ADDR_WIDTH'(d_w);

  // Flips swap pairs in place: read a, read b, then write a<-b, b<-a while
  // the next pair is read. Copies stream source reads into the other bank.
  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    ctrl_o.busy = (state_q != SEQ_IDLE);
    rd_addr_o   = a_addr;
    wr_addr_o   = wa_q;
    wr_data_o   = rdata_i;
    step        = 1'b0;
    unique case (state_q)
      SEQ_IDLE: begin
        if (start_i) begin
          state_d = ((code_i == XF_VFLIP) || (code_i == XF_HFLIP)) ? SEQ_FLIP : SEQ_COPY;
        end
      end
      SEQ_FLIP: begin
        ctrl_o.rd_en = 1'b1;
        rd_addr_o    = ph_q ? b_addr : a_addr;
        ctrl_o.wr_en = pend_q;
        wr_addr_o    = ph_q ? pb_q : pa_q;
        wr_data_o    = ph_q ? hold_q : rdata_i;
        if (ph_q) begin
          step = 1'b1;
          if (item_last) begin
            state_d = SEQ_DRAIN;
          end
        end
      end
      SEQ_COPY: begin
        ctrl_o.rd_en    = 1'b1;
        ctrl_o.wr_en    = wv_q;
        ctrl_o.wr_other = 1'b1;
        step            = 1'b1;
        if (item_last) begin
          state_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        if (is_flip) begin
          ctrl_o.wr_en = 1'b1;
          wr_addr_o    = ph_q ? pb_q : pa_q;
          wr_data_o    = ph_q ? hold_q : rdata_i;
          if (ph_q) begin
            ctrl_o.done = 1'b1;
            state_d     = SEQ_IDLE;
          end
        end else begin
          ctrl_o.wr_en     = wv_q;
          ctrl_o.wr_other  = 1'b1;
          ctrl_o.done      = 1'b1;
          ctrl_o.flip_bank = 1'b1;
          ctrl_o.swap_dims = is_rot;
          state_d          = SEQ_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      code_q  <= XF_VFLIP;
      i_q     <= '0;
      j_q     <= '0;
      rb_q    <= '0;
      ph_q    <= 1'b0;
      pend_q  <= 1'b0;
      wv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      wv_q    <= (state_q == SEQ_COPY);
      if ((state_q == SEQ_IDLE) && start_i) begin
        code_q <= code_i;
        i_q    <= '0;
        j_q    <= '0;
        rb_q   <= '0;
        ph_q   <= 1'b0;
        pend_q <= 1'b0;
      end else begin
        if ((state_q == SEQ_FLIP) || ((state_q == SEQ_DRAIN) && is_flip)) begin
          ph_q <= !ph_q;
        end
        if ((state_q == SEQ_FLIP) && ph_q) begin
          pend_q <= 1'b1;
        end
        if (step) begin
          if (row_end) begin
            j_q  <= '0;
            i_q  <= dim_t'(i_q + dim_t'(1));
            rb_q <= ADDR_WIDTH'(SW'(rb_q) + SW'(m_q));
          end else begin
            j_q <= dim_t'(j_q + dim_t'(1));
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == SEQ_IDLE) && start_i) begin
      n_q    <= rows_i;
      m_q    <= cols_i;
      imax_q <= (code_i == XF_VFLIP) ? dim_t'({1'b0, rows_i[DIM_W-1:1]} - dim_t'(1))
                                     : dim_t'(rows_i - dim_t'(1));
      jmax_q <= (code_i == XF_HFLIP) ? dim_t'({1'b0, cols_i[DIM_W-1:1]} - dim_t'(1))
                                     : dim_t'(cols_i - dim_t'(1));
    end
    if ((state_q == SEQ_FLIP) && ph_q) begin
      hold_q <= rdata_i;
      pa_q   <= a_addr;
      pb_q   <= b_addr;
    end
    if (state_q == SEQ_COPY) begin
      wa_q <= d_addr;
    end
  end

endmodule

@@ design/matrix_flip_rotate_engine.sv @@
// Matrix flip/rotate engine. Holds a rows x cols matrix (even sizes, 2 up to
// MAX_DIM) in two single-port-read banks. Load and read items share one
// row-major pointer; a read result appears on the output the cycle after
// the read is taken, and a new read or transform waits until that result is
// transferred, while loads keep flowing. Flips swap element pairs in place;
// rotations and quadrant moves copy into the other bank. A bank allows one
// read per cycle. Register writes reload the dimensions and reset the
// pointer; no clearing pass runs after reset.
module matrix_flip_rotate_engine import mfre_pkg::*; #(
  parameter int MAX_DIM    = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  mfre_in_if.sink              in_i,
  mfre_out_if.source           out_o
);

  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_TOP = MAX_DIM - (MAX_DIM % 2);
  localparam logic [DIM_W:0] TOP_V = (DIM_W + 1)'(DIM_TOP);
  localparam logic [DIM_W:0] MIN_V = (DIM_W + 1)'(2);

  function automatic dim_t eff_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W:0] t;
    t = {1'b0, v[CFG_W-1:1], 1'b0};
    if (t < MIN_V) begin
      t = MIN_V;
    end else if (t > TOP_V) begin
      t = TOP_V;
    end
    return t[DIM_W-1:0];
  endfunction

  logic [CFG_W-1:0] init_rows_q, init_cols_q;
  dim_t             rows_q, cols_q, prow_q, pcol_q;
  logic [AW-1:0]    ptr_q;
  logic             active_q, out_valid_q, out_last_q;
  logic [COORD_W-1:0] out_row_q, out_col_q;

  op_e       op;
  xform_e    code;
  seq_ctrl_t sc;
  logic      slot_free, accept, ld_fire, rd_fire, xf_start, at_last, row_done;
  logic [DATA_WIDTH-1:0] ld_data, rdata_a, rdata_b, rd_data, seq_wdata;
  logic [AW-1:0]         seq_raddr, seq_waddr;
  logic [VALUE_W-1:0]    rd_value;

  logic                  act_we, act_re, oth_we;
  logic [AW-1:0]         act_waddr, act_raddr;
  logic [DATA_WIDTH-1:0] act_wdata;

  assign op        = op_e'(in_i.operation);
  assign code      = xform_e'(in_i.transform_code);
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    unique case (op)
      OP_LOAD:  in_i.ready = !sc.busy;
      OP_XFORM: in_i.ready = !sc.busy && slot_free;
      OP_READ:  in_i.ready = !sc.busy && slot_free;
      default:  in_i.ready = !sc.busy;
    endcase
  end

  assign accept   = in_i.valid && in_i.ready;
  assign ld_fire  = accept && (op == OP_LOAD);
  assign rd_fire  = accept && (op == OP_READ);
  assign xf_start = accept && (op == OP_XFORM) && (code <= XF_QUAD_CCW);

  assign row_done = (pcol_q == dim_t'(cols_q - dim_t'(1)));
  assign at_last  = row_done && (prow_q == dim_t'(rows_q - dim_t'(1)));

  if (DATA_WIDTH > VALUE_W) begin : g_wide
    assign ld_data  = {{(DATA_WIDTH - VALUE_W){in_i.value[VALUE_W-1]}}, in_i.value};
    assign rd_value = rd_data[VALUE_W-1:0];
  end else if (DATA_WIDTH == VALUE_W) begin : g_equal
    assign ld_data  = in_i.value;
    assign rd_value = rd_data;
  end else begin : g_narrow
    assign ld_data  = in_i.value[DATA_WIDTH-1:0];
    assign rd_value = {{(VALUE_W - DATA_WIDTH){rd_data[DATA_WIDTH-1]}}, rd_data};
  end

  mfre_seq #(
    .ADDR_WIDTH (AW),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (xf_start),
    .code_i    (code),
    .rows_i    (rows_q),
    .cols_i    (cols_q),
    .rdata_i   (rd_data),
    .ctrl_o    (sc),
    .rd_addr_o (seq_raddr),
    .wr_addr_o (seq_waddr),
    .wr_data_o (seq_wdata)
  );

  assign act_we    = ld_fire || (sc.wr_en && !sc.wr_other);
  assign act_waddr = sc.busy ? seq_waddr : ptr_q;
  assign act_wdata = sc.busy ? seq_wdata : ld_data;
  assign act_re    = rd_fire || sc.rd_en;
  assign act_raddr = sc.busy ? seq_raddr : ptr_q;
  assign oth_we    = sc.wr_en && sc.wr_other;

  mfre_bank #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .ADDR_WIDTH (AW)
  ) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (active_q ? oth_we : act_we),
    .waddr_i (active_q ? seq_waddr : act_waddr),
    .wdata_i (active_q ? seq_wdata : act_wdata),
    .re_i    (!active_q && act_re),
    .raddr_i (act_raddr),
    .rdata_o (rdata_a)
  );

  mfre_bank #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH),
    .ADDR_WIDTH (AW)
  ) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (active_q ? act_we : oth_we),
    .waddr_i (active_q ? act_waddr : seq_waddr),
    .wdata_i (active_q ? act_wdata : seq_wdata),
    .re_i    (active_q && act_re),
    .raddr_i (act_raddr),
    .rdata_o (rdata_b)
  );

  assign rd_data = active_q ? rdata_b : rdata_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_rows_q <= DIM_RESET;
      init_cols_q <= DIM_RESET;
      rows_q      <= DIM_RESET;
      cols_q      <= DIM_RESET;
      active_q    <= 1'b0;
      ptr_q       <= '0;
      prow_q      <= '0;
      pcol_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ROWS: begin
            init_rows_q <= cfg_wdata_i;
            rows_q      <= eff_dim(cfg_wdata_i);
            cols_q      <= eff_dim(init_cols_q);
          end
          CFG_COLS: begin
            init_cols_q <= cfg_wdata_i;
            rows_q      <= eff_dim(init_rows_q);
            cols_q      <= eff_dim(cfg_wdata_i);
          end
        endcase
      end
      if (cfg_we_i || xf_start) begin
        ptr_q  <= '0;
        prow_q <= '0;
        pcol_q <= '0;
      end else if (ld_fire || rd_fire) begin
        priority if (at_last) begin
          ptr_q  <= '0;
          prow_q <= '0;
          pcol_q <= '0;
        end else if (row_done) begin
          ptr_q  <= AW'(ptr_q + 1'b1);
          prow_q <= dim_t'(prow_q + dim_t'(1));
          pcol_q <= '0;
        end else begin
          ptr_q  <= AW'(ptr_q + 1'b1);
          pcol_q <= dim_t'(pcol_q + dim_t'(1));
        end
      end
      if (sc.done) begin
        if (sc.flip_bank) begin
          active_q <= !active_q;
        end
        if (sc.swap_dims) begin
          rows_q <= cols_q;
          cols_q <= rows_q;
        end
      end
      if (rd_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_fire) begin
      out_row_q  <= prow_q[COORD_W-1:0];
      out_col_q  <= pcol_q[COORD_W-1:0];
      out_last_q <= at_last;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.value_res = rd_value;
  assign out_o.row       = out_row_q;
  assign out_o.col       = out_col_q;
  assign out_o.last      = out_last_q;

endmodule

@@ design/mfre_checker.sv @@
`include "assert_macros.svh"

module mfre_checker import mfre_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic [OP_W-1:0]           in_operation_i,
  input logic [XF_W-1:0]           in_code_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [VALUE_W-1:0] out_value_i,
  input logic [COORD_W-1:0]        out_row_i,
  input logic [COORD_W-1:0]        out_col_i,
  input logic                      out_last_i
);

  logic in_xfer, out_stall;
  logic [VALUE_W+2*COORD_W:0] out_word;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_word  = {out_value_i, out_row_i, out_col_i, out_last_i};

  `ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_stall, out_valid_i)

  `ASSERT_NEXT(a_out_payload_held, clk_i, rst_ni, out_stall, $stable(out_word))

  `ASSERT_SAME(a_result_from_read, clk_i, rst_ni, $rose(out_valid_i), $past(in_xfer && (in_operation_i == OP_READ)))

  `ASSERT_NEXT(a_transform_stalls, clk_i, rst_ni, in_xfer && (in_operation_i == OP_XFORM) && (in_code_i <= XF_QUAD_CCW), !in_ready_i)

endmodule

bind matrix_flip_rotate_engine mfre_checker u_mfre_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_operation_i (in_i.operation),
  .in_code_i      (in_i.transform_code),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_value_i    (out_o.value_res),
  .out_row_i      (out_o.row),
  .out_col_i      (out_o.col),
  .out_last_i     (out_o.last)
);

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfre_pkg::*;

  localparam int MAX_DIM = 128;
  localparam int CELLS = MAX_DIM * MAX_DIM;
  localparam int STALL_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [XF_W-1:0] XF_SPARE_LO = 3'd6;
  localparam logic [XF_W-1:0] XF_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [COORD_W-1:0]        row;
    logic [COORD_W-1:0]        col;
    logic                      last;
  } element_t;

  class matrix_tracker;
    logic [VALUE_W-1:0] mem [2][CELLS];
    int                 filled [2];   // written prefix length per bank
    int                 bank_sel;
    int                 rows;
    int                 cols;
    int                 ptr;
    dim_t               rows_reg;
    dim_t               cols_reg;
    element_t           readouts [$];
    int                 errors;

    function new();
      bank_sel = 0;
      filled[0] = 0;
      filled[1] = 0;
      errors = 0;
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      reload();
    endfunction

    function int clamp_dim(dim_t v);
      int d;
      d = int'(v) & ~1;
      if (d < 2) d = 2;
      if (d > (MAX_DIM & ~1)) d = MAX_DIM & ~1;
      return d;
    endfunction

    function void reload();
      rows = clamp_dim(rows_reg);
      cols = clamp_dim(cols_reg);
      ptr = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, dim_t data);
      if (idx == CFG_ROWS) rows_reg = data;
      else cols_reg = data;
      reload();
    endfunction

    function bit can_read();
      int p;
      p = (ptr >= rows * cols) ? 0 : ptr;
      return p < filled[bank_sel];
    endfunction

    function bit can_xform();
      return filled[bank_sel] >= rows * cols;
    endfunction

    function void transform(xform_e code);
      int n, m, hn, hm, i, j, d, other;
      logic [VALUE_W-1:0] t;
      bit top, left;
      n = rows;
      m = cols;
      hn = n / 2;
      hm = m / 2;
      other = 1 - bank_sel;
      case (code)
        XF_VFLIP: begin
          for (i = 0; i < hn; i++)
            for (j = 0; j < m; j++) begin
              t = mem[bank_sel][i*m + j];
              mem[bank_sel][i*m + j] = mem[bank_sel][(n-1-i)*m + j];
              mem[bank_sel][(n-1-i)*m + j] = t;
            end
        end
        XF_HFLIP: begin
          for (i = 0; i < n; i++)
            for (j = 0; j < hm; j++) begin
              t = mem[bank_sel][i*m + j];
              mem[bank_sel][i*m + j] = mem[bank_sel][i*m + (m-1-j)];
              mem[bank_sel][i*m + (m-1-j)] = t;
            end
        end
        default: begin
          for (i = 0; i < n; i++)
            for (j = 0; j < m; j++) begin
              top = i < hn;
              left = j < hm;
              case (code)
                XF_ROT_CW:  d = j*n + (n-1-i);
                XF_ROT_CCW: d = (m-1-j)*n + i;
                XF_QUAD_CW: begin
                  if (top && left) d = i*m + (j+hm);
                  else if (top) d = (i+hn)*m + j;
                  else if (!left) d = i*m + (j-hm);
                  else d = (i-hn)*m + j;
                end
                default: begin
                  if (top && left) d = (i+hn)*m + j;
                  else if (top) d = i*m + (j-hm);
                  else if (!left) d = (i-hn)*m + j;
                  else d = i*m + (j+hm);
                end
              endcase
              mem[other][d] = mem[bank_sel][i*m + j];
            end
          if (filled[other] < n * m) filled[other] = n * m;
          bank_sel = other;
          if (code == XF_ROT_CW || code == XF_ROT_CCW) begin
            rows = m;
            cols = n;
          end
        end
      endcase
      ptr = 0;
    endfunction

    function void take_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                            logic [XF_W-1:0] code);
      int size;
      element_t e;
      size = rows * cols;
      if (ptr >= size) ptr = 0;
      case (op)
        OP_LOAD: begin
          mem[bank_sel][ptr] = value;
          if (ptr == filled[bank_sel]) filled[bank_sel]++;
          ptr = (ptr + 1 >= size) ? 0 : ptr + 1;
        end
        OP_XFORM: begin
          if (code <= XF_QUAD_CCW) transform(xform_e'(code));
        end
        OP_READ: begin
          e.value = mem[bank_sel][ptr];
          e.row = COORD_W'(ptr / cols);
          e.col = COORD_W'(ptr % cols);
          e.last = (ptr + 1 >= size);
          readouts.push_back(e);
          ptr = e.last ? 0 : ptr + 1;
        end
        default: ;
      endcase
    endfunction

    function void check_element(logic signed [VALUE_W-1:0] value, logic [COORD_W-1:0] row,
                                logic [COORD_W-1:0] col, logic last);
      element_t e;
      if (readouts.size() == 0) begin
        $error("unexpected element: value_res %0d row %0d col %0d last %0d",
               value, row, col, last);
        errors++;
        return;
      end
      e = readouts.pop_front();
      if (value !== e.value) begin
        $error("value_res: expected %0d, got %0d", e.value, value);
        errors++;
      end
      if (row !== e.row) begin
        $error("row: expected %0d, got %0d", e.row, row);
        errors++;
      end
      if (col !== e.col) begin
        $error("col: expected %0d, got %0d", e.col, col);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  mfre_in_if  in_ch ();
  mfre_out_if out_ch ();

  matrix_tracker model = new();
  int send_pct;
  int recv_pct;
  int hold_req;

  matrix_flip_rotate_engine #(
    .MAX_DIM   (MAX_DIM),
    .DATA_WIDTH(VALUE_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                           logic [XF_W-1:0] code);
    while ($urandom_range(99) < send_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.value <= value;
    in_ch.transform_code <= code;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    model.take_item(op, value, code);
  endtask

  task automatic load_elem();
    send_item(OP_LOAD, rand_value(), XF_W'($urandom_range(7)));
  endtask

  // falls back to a load where the element under the pointer was never written
  task automatic read_elem();
    if (model.can_read()) send_item(OP_READ, $urandom, XF_W'($urandom_range(7)));
    else load_elem();
  endtask

  task automatic apply_xform(xform_e code);
    if (model.can_xform()) send_item(OP_XFORM, $urandom, code);
    else load_elem();
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (model.readouts.size() != 0) @(posedge clk_i);
    repeat (model.rows * model.cols + 10) @(posedge clk_i);
  endtask

  task automatic program_dims(dim_t r, dim_t c);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ROWS;
    cfg_wdata_i <= r;
    @(posedge clk_i);
    model.write_reg(CFG_ROWS, r);
    cfg_idx_i <= CFG_COLS;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    model.write_reg(CFG_COLS, c);
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed();
    logic [VALUE_W-1:0] corner [4];
    corner = '{32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0000_0000};
    foreach (corner[k]) send_item(OP_LOAD, corner[k], XF_SPARE_HI);
    repeat (4) send_item(OP_READ, $urandom, XF_W'($urandom_range(7)));
    for (int c = XF_VFLIP; c <= XF_QUAD_CCW; c++) begin
      send_item(OP_XFORM, $urandom, XF_W'(c));
      send_item(OP_READ, $urandom, XF_W'($urandom_range(7)));
    end
    send_item(OP_XFORM, $urandom, XF_SPARE_LO);
    send_item(OP_XFORM, $urandom, XF_SPARE_HI);
    send_item(OP_UNUSED, '1, XF_SPARE_HI);
    send_item(OP_READ, $urandom, XF_W'($urandom_range(7)));
  endtask

  task automatic run_random(int n_items);
    int count, len, size, pick;
    count = 0;
    while (count < n_items) begin
      size = model.rows * model.cols;
      pick = $urandom_range(99);
      if (pick < 35) begin
        len = ($urandom_range(3) == 0) ? size : $urandom_range(1, 16);
        repeat (len) read_elem();
        count += len;
      end else if (pick < 55) begin
        len = $urandom_range(1, 12);
        repeat (len) load_elem();
        count += len;
      end else if (pick < 80) begin
        apply_xform(xform_e'($urandom_range(XF_VFLIP, XF_QUAD_CCW)));
        count++;
        if (size <= 64 && $urandom_range(1)) begin
          repeat (size) read_elem();
          count += size;
        end
      end else if (pick < 90) begin
        if ($urandom_range(1)) send_item(OP_UNUSED, $urandom, XF_W'($urandom_range(7)));
        else send_item(OP_XFORM, $urandom, XF_W'($urandom_range(XF_SPARE_LO, XF_SPARE_HI)));
      end else begin
        if ($urandom_range(1)) read_elem();
        else load_elem();
        count++;
      end
    end
  endtask

  task automatic run_phase(dim_t r, dim_t c, int s_pct, int r_pct, int n_items, bit squeeze);
    settle();
    program_dims(r, c);
    send_pct = s_pct;
    recv_pct = r_pct;
    if (!model.can_xform()) repeat (model.rows * model.cols) load_elem();
    if (squeeze) begin
      // output held off while reads keep coming, then wait for everything out
      hold_req = 200;
      repeat (40) read_elem();
      in_ch.valid <= 1'b0;
      while (model.readouts.size() != 0) @(posedge clk_i);
    end
    run_random(n_items);
  endtask

  initial begin : sink_side
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready)
        model.check_element(out_ch.value_res, out_ch.row, out_ch.col, out_ch.last);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    send_pct = 0;
    recv_pct = 0;
    hold_req = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_ROWS;
    cfg_wdata_i <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.value <= '0;
    in_ch.transform_code <= XF_VFLIP;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed();
    run_random(40);
    run_phase(8'd255, 8'd0, 51, 0, 20, 1'b0);
    run_phase(8'd1, 8'd255, 0, 51, 20, 1'b0);
    run_phase(8'd6, 8'd4, 37, 37, 30, 1'b0);
    run_phase(8'd3, 8'd9, 0, 0, 30, 1'b1);
    run_phase(8'd8, 8'd10, 51, 0, 30, 1'b0);
    run_phase(8'd4, 8'd4, 0, 51, 30, 1'b0);
    run_phase(8'd12, 8'd6, 37, 37, 30, 1'b0);
    run_phase(8'd2, 8'd2, 0, 0, 20, 1'b0);
    settle();

    if (model.errors == 0 && model.readouts.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/mfre_pkg.sv
design/mfre_in_if.sv
design/mfre_out_if.sv
design/mfre_bank.sv
design/mfre_seq.sv
design/matrix_flip_rotate_engine.sv
design/mfre_checker.sv
tb/tb.sv
